/* design/grid_transpose_mirror_assert.svh */
// Assertion macros for the grid transpose block.
`ifndef GRID_TRANSPOSE_MIRROR_ASSERT_SVH
`define GRID_TRANSPOSE_MIRROR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GTM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grid_transpose_mirror assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grid_transpose_mirror assertion failed");

`endif

/* design/gtm_pkg.sv */
package gtm_pkg;

    localparam int MAX_DIM_DEF    = 256;
    localparam int CELL_WIDTH_DEF = 64;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y  = 2'd3;

    localparam logic [CFG_W-1:0] GRID_COLS_RST = 9'd16;
    localparam logic [CFG_W-1:0] GRID_ROWS_RST = 9'd16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    typedef struct packed {
        logic                 status;
        logic                 last_cell;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } t_fetch_info;

endpackage

/* design/gtm_ram.sv */
module gtm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gtm_seq.sv */
module gtm_seq #(
    parameter int MAX_DIM = gtm_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_restart,
    input  logic                             i_load,
    input  logic                             i_fetch,
    input  logic [$clog2(MAX_DIM)-1:0]       i_cols_last,
    input  logic [$clog2(MAX_DIM)-1:0]       i_rows_last,
    input  logic                             i_mirror_x,
    input  logic                             i_mirror_y,
    output logic                             o_wr_en,
    output logic [2*$clog2(MAX_DIM)-1:0]     o_wr_addr,
    output logic                             o_rd_en,
    output logic [2*$clog2(MAX_DIM)-1:0]     o_rd_addr,
    output gtm_pkg::t_fetch_info             o_info
);

    localparam int IDX_W = $clog2(MAX_DIM);

    logic [IDX_W-1:0] r_load_col, n_load_col;
    logic [IDX_W-1:0] r_load_row, n_load_row;
    logic             r_full, n_full;
    logic [IDX_W-1:0] r_read_row, n_read_row;
    logic [IDX_W-1:0] r_read_col, n_read_col;

    logic [IDX_W-1:0] w_lcol;
    logic [IDX_W-1:0] w_lrow;
    logic [IDX_W-1:0] w_src_col;
    logic [IDX_W-1:0] w_src_row;
    logic             w_last;

    assign w_lcol    = r_full ? '0 : r_load_col;
    assign w_lrow    = r_full ? '0 : r_load_row;
    assign w_src_col = i_mirror_x ? (i_cols_last - r_read_row) : r_read_row;
    assign w_src_row = i_mirror_y ? (i_rows_last - r_read_col) : r_read_col;
    assign w_last    = (r_read_row == i_cols_last) && (r_read_col == i_rows_last);

    assign o_wr_en   = i_load;
    assign o_wr_addr = {w_lrow, w_lcol};
    assign o_rd_en   = i_fetch & r_full;
    assign o_rd_addr = {w_src_row, w_src_col};

    always_comb begin
        o_info = '0;
        if (r_full) begin
            o_info.status    = gtm_pkg::STATUS_OK;
            o_info.last_cell = w_last;
            o_info.row       = gtm_pkg::OUT_IDX_W'(r_read_row);
            o_info.col       = gtm_pkg::OUT_IDX_W'(r_read_col);
        end else begin
            o_info.status    = gtm_pkg::STATUS_NOT_READY;
        end
    end

    always_comb begin
        n_load_col = r_load_col;
        n_load_row = r_load_row;
        n_full     = r_full;
        n_read_row = r_read_row;
        n_read_col = r_read_col;
        if (i_restart) begin
            n_load_col = '0;
            n_load_row = '0;
            n_full     = 1'b0;
            n_read_row = '0;
            n_read_col = '0;
        end else if (i_load) begin
            n_full = 1'b0;
            if (w_lcol == i_cols_last) begin
                n_load_col = '0;
                if (w_lrow == i_rows_last) begin
                    n_load_row = '0;
                    n_full     = 1'b1;
                    n_read_row = '0;
                    n_read_col = '0;
                end else begin
                    n_load_row = w_lrow + IDX_W'(1);
                end
            end else begin
                n_load_col = w_lcol + IDX_W'(1);
                n_load_row = w_lrow;
            end
        end else if (i_fetch && r_full) begin
            if (r_read_col == i_rows_last) begin
                n_read_col = '0;
                n_read_row = (r_read_row == i_cols_last) ? '0 : r_read_row + IDX_W'(1);
            end else begin
                n_read_col = r_read_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col <= '0;
            r_load_row <= '0;
            r_full     <= 1'b0;
            r_read_row <= '0;
            r_read_col <= '0;
        end else begin
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
            r_full     <= n_full;
            r_read_row <= n_read_row;
            r_read_col <= n_read_col;
        end
    end

endmodule

/* design/grid_transpose_mirror.sv */
// Grid transpose with optional mirroring. Load transactions (op 0) write cells
// of the input grid in row-major order into an on-chip cell store of
// 2^(2*ceil(log2(MAX_DIM))) words, addressed as row * 2^ceil(log2(MAX_DIM)) + col;
// fetch transactions (op 1) return the next cell of the transposed grid, one
// result each, with status 1 and zero payload while the grid is not yet full.
// A load writes its cell directly, and loads stream at one per cycle while
// o_in_ready is high. The cell store's registered read returns in the cycle
// after a fetch transaction, and the output register takes it at the
// following edge, raising o_out_valid. The input takes no new transaction
// during that read, nor while a result is stalled at the output, so the next
// transaction waits until a fetch's read has finished. The store needs no
// clearing after reset. Write grid_cols or grid_rows to restart loading; write
// configuration only while no transaction is in flight.
module grid_transpose_mirror #(
    parameter int MAX_DIM    = gtm_pkg::MAX_DIM_DEF,
    parameter int CELL_WIDTH = gtm_pkg::CELL_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gtm_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [CELL_WIDTH-1:0]               i_cell_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [CELL_WIDTH-1:0]               o_out_value,
    output logic [gtm_pkg::OUT_IDX_W-1:0]       o_out_row,
    output logic [gtm_pkg::OUT_IDX_W-1:0]       o_out_col,
    output logic                                o_last_cell,
    output logic                                o_status
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int AW    = 2 * IDX_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EW    = (DIM_W > gtm_pkg::CFG_W) ? DIM_W : gtm_pkg::CFG_W;

    function automatic logic [IDX_W-1:0] f_last(input logic [gtm_pkg::CFG_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (ext == '0) begin
            f_last = '0;
        end else if (ext > EW'(MAX_DIM)) begin
            f_last = IDX_W'(MAX_DIM - 1);
        end else begin
            f_last = IDX_W'(ext - EW'(1));
        end
    endfunction

    logic [gtm_pkg::CFG_W-1:0] r_grid_cols;
    logic [gtm_pkg::CFG_W-1:0] r_grid_rows;
    logic                      r_mirror_x;
    logic                      r_mirror_y;

    logic                      r_pend;
    gtm_pkg::t_fetch_info      r_pend_info;
    logic                      r_out_valid;
    logic [CELL_WIDTH-1:0]     r_out_value;
    gtm_pkg::t_fetch_info      r_out_info;

    logic                      w_accept;
    logic                      w_load;
    logic                      w_fetch;
    logic                      w_restart;
    logic [IDX_W-1:0]          w_cols_last;
    logic [IDX_W-1:0]          w_rows_last;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic [CELL_WIDTH-1:0]     w_rd_data;
    gtm_pkg::t_fetch_info      w_info;

    assign o_in_ready  = !r_pend && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = w_accept && (i_op == gtm_pkg::OP_LOAD);
    assign w_fetch     = w_accept && (i_op == gtm_pkg::OP_FETCH);
    assign w_restart   = i_cfg_we && ((i_cfg_idx == gtm_pkg::REG_GRID_COLS) ||
                                      (i_cfg_idx == gtm_pkg::REG_GRID_ROWS));
    assign w_cols_last = f_last(r_grid_cols);
    assign w_rows_last = f_last(r_grid_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= gtm_pkg::GRID_COLS_RST;
            r_grid_rows <= gtm_pkg::GRID_ROWS_RST;
            r_mirror_x  <= 1'b0;
            r_mirror_y  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtm_pkg::REG_GRID_COLS: begin
                    r_grid_cols <= i_cfg_data;
                end
                gtm_pkg::REG_GRID_ROWS: begin
                    r_grid_rows <= i_cfg_data;
                end
                gtm_pkg::REG_MIRROR_X: begin
                    r_mirror_x <= i_cfg_data[0];
                end
                gtm_pkg::REG_MIRROR_Y: begin
                    r_mirror_y <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    gtm_seq #(
        .MAX_DIM(MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_load      (w_load),
        .i_fetch     (w_fetch),
        .i_cols_last (w_cols_last),
        .i_rows_last (w_rows_last),
        .i_mirror_x  (r_mirror_x),
        .i_mirror_y  (r_mirror_y),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_info      (w_info)
    );

    gtm_ram #(
        .WIDTH(CELL_WIDTH),
        .DEPTH(1 << AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (i_cell_value),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= w_fetch;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_pend_info <= w_info;
        end
        if (r_pend) begin
            r_out_info  <= r_pend_info;
            r_out_value <= (r_pend_info.status == gtm_pkg::STATUS_OK) ? w_rd_data : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_row   = r_out_info.row;
    assign o_out_col   = r_out_info.col;
    assign o_last_cell = r_out_info.last_cell;
    assign o_status    = r_out_info.status;

endmodule

/* design/gtm_checker.sv */
`include "grid_transpose_mirror_assert.svh"

module gtm_checker #(
    parameter int CELL_WIDTH = gtm_pkg::CELL_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_op,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [CELL_WIDTH-1:0]         o_out_value,
    input logic [gtm_pkg::OUT_IDX_W-1:0] o_out_row,
    input logic [gtm_pkg::OUT_IDX_W-1:0] o_out_col,
    input logic                          o_last_cell,
    input logic                          o_status
);

    logic w_fetch_acc;

    assign w_fetch_acc = i_in_valid && o_in_ready && (i_op == gtm_pkg::OP_FETCH);

    // Hold a stalled result.
    `GTM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_value) && $stable(o_status))

    // Zero the payload of a not-ready result.
    `GTM_ASSERT_IMPL(a_err_zero, o_out_valid && o_status, o_out_value == '0 && o_out_row == '0 && o_out_col == '0 && !o_last_cell)

    // Block the input while a fetch reads the store.
    `GTM_ASSERT_NEXT(a_fetch_busy, w_fetch_acc, !o_in_ready)

    // Present a result once the read returns and the output register takes it.
    `GTM_ASSERT_IMPL(a_fetch_result, $past(w_fetch_acc, 2), o_out_valid)

endmodule

bind grid_transpose_mirror gtm_checker #(.CELL_WIDTH(CELL_WIDTH)) u_gtm_checker (.*);
